[rtl/assert_macros.svh]
// Assertion helpers for the checker in oks_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define AST_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/oks_pkg.sv]
`timescale 1ns / 1ps
package oks_pkg;

    localparam int CAPACITY = 64;
    localparam int KEY_BITS = 32;
    localparam int CMD_W    = 3;
    localparam int RANK_W   = 8;
    localparam int STAT_W   = 2;
    localparam int OCC_W    = 7;

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CMP_W  = CNT_W + RANK_W;
    localparam int GRP    = 8;
    localparam int NGRP   = (CAPACITY + GRP - 1) / GRP;

    localparam int IN_BITS  = CMD_W + KEY_BITS + RANK_W;
    localparam int OUT_BITS = KEY_BITS + STAT_W + OCC_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // bit offsets inside tdata
    localparam int IN_KEY_LO   = CMD_W;
    localparam int IN_RANK_LO  = CMD_W + KEY_BITS;
    localparam int OUT_STAT_LO = KEY_BITS;
    localparam int OUT_OCC_LO  = KEY_BITS + STAT_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 3'd0,
        CMD_DELETE = 3'd1,
        CMD_FIND   = 3'd2,
        CMD_MIN    = 3'd3,
        CMD_MAX    = 3'd4,
        CMD_RANK   = 3'd5
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE   = 2'd0,
        ST_ABSENT = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

    // control broadcast to every cell
    typedef struct packed {
        logic                eval;
        logic                apply;
        logic [CMD_W-1:0]    cmd;
        logic [KEY_BITS-1:0] key;
        logic [RANK_W-1:0]   rank;
        logic [CNT_W-1:0]    count;
        logic                present;
        logic                full;
    } cell_ctl_t;

endpackage

[rtl/oks_cell.sv]
`timescale 1ns / 1ps
module oks_cell
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  oks_pkg::cell_ctl_t            ctl,
    input  logic [oks_pkg::IDX_W-1:0]     idx,
    input  logic [oks_pkg::KEY_BITS-1:0]  left_key,
    input  logic                          left_lt,
    input  logic [oks_pkg::KEY_BITS-1:0]  right_key,
    output logic [oks_pkg::KEY_BITS-1:0]  key,
    output logic                          lt,
    output logic                          eq,
    output logic                          sel,
    output logic [oks_pkg::KEY_BITS-1:0]  sel_key
);

    logic [oks_pkg::KEY_BITS-1:0] key_reg, key_next;
    logic                         lt_reg, lt_next;
    logic                         eq_reg, eq_next;
    logic                         sel_reg, sel_next;
    logic                         vld;
    logic [oks_pkg::CNT_W-1:0]    idx_ext;
    logic [oks_pkg::CMP_W-1:0]    rank_ext;
    logic [oks_pkg::CMP_W-1:0]    pos_ext;

    assign idx_ext  = oks_pkg::CNT_W'(idx);
    assign vld      = idx_ext < ctl.count;
    assign rank_ext = oks_pkg::CMP_W'(ctl.rank);
    assign pos_ext  = oks_pkg::CMP_W'(idx) + oks_pkg::CMP_W'(1);

    always_comb
    begin
        key_next = key_reg;
        lt_next  = lt_reg;
        eq_next  = eq_reg;
        sel_next = sel_reg;
        if (ctl.eval)
        begin
            lt_next  = vld && ($signed(key_reg) < $signed(ctl.key));
            eq_next  = vld && (key_reg == ctl.key);
            sel_next = vld &&
                ((ctl.cmd == oks_pkg::CMD_MIN  && idx_ext == '0) ||
                 (ctl.cmd == oks_pkg::CMD_MAX  && idx_ext + oks_pkg::CNT_W'(1) == ctl.count) ||
                 (ctl.cmd == oks_pkg::CMD_RANK && rank_ext == pos_ext));
        end
        else if (ctl.apply && !lt_reg)
        begin
            // cells at or after the insert/delete point shift toward the gap
            if (ctl.cmd == oks_pkg::CMD_INSERT && !ctl.present && !ctl.full)
                key_next = left_lt ? ctl.key : left_key;
            else if (ctl.cmd == oks_pkg::CMD_DELETE && ctl.present)
                key_next = right_key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lt_reg  <= 1'b0;
            eq_reg  <= 1'b0;
            sel_reg <= 1'b0;
        end
        else
        begin
            lt_reg  <= lt_next;
            eq_reg  <= eq_next;
            sel_reg <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign key     = key_reg;
    assign lt      = lt_reg;
    assign eq      = eq_reg;
    assign sel     = sel_reg;
    assign sel_key = sel_reg ? key_reg : '0;

endmodule

[rtl/oks_reduce.sv]
`timescale 1ns / 1ps
module oks_reduce
(
    input  logic                         clk,
    input  logic                         load,
    input  logic [oks_pkg::KEY_BITS-1:0] sel_keys [oks_pkg::CAPACITY],
    output logic [oks_pkg::KEY_BITS-1:0] value
);

    logic [oks_pkg::KEY_BITS-1:0] part_reg  [oks_pkg::NGRP];
    logic [oks_pkg::KEY_BITS-1:0] part_next [oks_pkg::NGRP];

    // first level: OR of up to eight one-hot masked keys per group
    always_comb
    begin
        for (int g = 0; g < oks_pkg::NGRP; g++)
        begin
            part_next[g] = '0;
            for (int j = 0; j < oks_pkg::GRP; j++)
            begin
                if (g * oks_pkg::GRP + j < oks_pkg::CAPACITY)
                    part_next[g] = part_next[g] | sel_keys[g * oks_pkg::GRP + j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            part_reg <= part_next;
    end

    always_comb
    begin
        value = '0;
        for (int g = 0; g < oks_pkg::NGRP; g++)
            value = value | part_reg[g];
    end

endmodule

[rtl/ordered_key_set_engine_unit.sv]
`timescale 1ns / 1ps
// A request passes the EVAL (compare), APPLY (shift, reduce load) and REDUCE (output load) states;
// REDUCE waits while the result register is full. A new request is taken only in IDLE, once the
// result register is loaded, even while that result still waits on m_tready.
// The row of 64 compare-and-shift cells applies an insert or delete in the single APPLY state.
// Reset (rst_n low, asynchronous) empties the set; the key cells are not cleared.
module ordered_key_set_engine_unit
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [oks_pkg::IN_W-1:0]    s_tdata,   // cmd, key, rank, zero pad
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [oks_pkg::OUT_W-1:0]   m_tdata    // value, status, occupancy, zero pad
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_APPLY,
        S_REDUCE
    } state_t;

    state_t                          state_reg, state_next;
    logic [oks_pkg::CMD_W-1:0]       cmd_reg, cmd_next;
    logic [oks_pkg::KEY_BITS-1:0]    key_reg, key_next;
    logic [oks_pkg::RANK_W-1:0]      rank_reg, rank_next;
    logic [oks_pkg::CNT_W-1:0]       count_reg, count_next;
    logic                            present_reg, present_next;
    logic                            full_reg, full_next;
    logic                            anysel_reg, anysel_next;
    logic                            m_valid_reg, m_valid_next;
    logic [oks_pkg::OUT_W-1:0]       m_data_reg, m_data_next;

    oks_pkg::cell_ctl_t              ctl;
    logic [oks_pkg::KEY_BITS-1:0]    key_vec   [oks_pkg::CAPACITY];
    logic [oks_pkg::KEY_BITS-1:0]    left_vec  [oks_pkg::CAPACITY];
    logic [oks_pkg::KEY_BITS-1:0]    right_vec [oks_pkg::CAPACITY];
    logic [oks_pkg::KEY_BITS-1:0]    sel_keys  [oks_pkg::CAPACITY];
    logic [oks_pkg::CAPACITY-1:0]    lt_vec, left_lt_vec, eq_vec, sel_vec;
    logic [oks_pkg::KEY_BITS-1:0]    red_value;
    logic                            present_c, full_c;
    logic [oks_pkg::KEY_BITS-1:0]    res_value;
    oks_pkg::status_t                res_status;

    assign present_c = |eq_vec;
    assign full_c    = count_reg == oks_pkg::CNT_W'(oks_pkg::CAPACITY);

    always_comb
    begin
        ctl.eval    = state_reg == S_EVAL;
        ctl.apply   = state_reg == S_APPLY;
        ctl.cmd     = cmd_reg;
        ctl.key     = key_reg;
        ctl.rank    = rank_reg;
        ctl.count   = count_reg;
        ctl.present = present_c;
        ctl.full    = full_c;
    end

    for (genvar i = 0; i < oks_pkg::CAPACITY; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            assign left_vec[i]    = '0;
            assign left_lt_vec[i] = 1'b1;
        end
        else
        begin : g_mid
            assign left_vec[i]    = key_vec[i-1];
            assign left_lt_vec[i] = lt_vec[i-1];
        end
        if (i == oks_pkg::CAPACITY - 1)
        begin : g_last
            assign right_vec[i] = key_vec[i];
        end
        else
        begin : g_inner
            assign right_vec[i] = key_vec[i+1];
        end

        oks_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .idx       (oks_pkg::IDX_W'(i)),
            .left_key  (left_vec[i]),
            .left_lt   (left_lt_vec[i]),
            .right_key (right_vec[i]),
            .key       (key_vec[i]),
            .lt        (lt_vec[i]),
            .eq        (eq_vec[i]),
            .sel       (sel_vec[i]),
            .sel_key   (sel_keys[i])
        );
    end

    oks_reduce u_reduce
    (
        .clk      (clk),
        .load     (ctl.apply),
        .sel_keys (sel_keys),
        .value    (red_value)
    );

    // result of the finished request
    always_comb
    begin
        res_value  = '1;
        res_status = oks_pkg::ST_ABSENT;
        unique case (cmd_reg)
            oks_pkg::CMD_INSERT:
            begin
                if (present_reg || !full_reg)
                begin
                    res_value  = key_reg;
                    res_status = oks_pkg::ST_DONE;
                end
                else
                    res_status = oks_pkg::ST_FULL;
            end
            oks_pkg::CMD_DELETE, oks_pkg::CMD_FIND:
            begin
                if (present_reg)
                begin
                    res_value  = key_reg;
                    res_status = oks_pkg::ST_DONE;
                end
            end
            oks_pkg::CMD_MIN, oks_pkg::CMD_MAX, oks_pkg::CMD_RANK:
            begin
                if (anysel_reg)
                begin
                    res_value  = red_value;
                    res_status = oks_pkg::ST_DONE;
                end
            end
            default:
            begin
                res_value  = '1;
                res_status = oks_pkg::ST_ABSENT;
            end
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        key_next     = key_reg;
        rank_next    = rank_reg;
        count_next   = count_reg;
        present_next = present_reg;
        full_next    = full_reg;
        anysel_next  = anysel_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next   = s_tdata[oks_pkg::CMD_W-1:0];
                    key_next   = s_tdata[oks_pkg::IN_KEY_LO +: oks_pkg::KEY_BITS];
                    rank_next  = s_tdata[oks_pkg::IN_RANK_LO +: oks_pkg::RANK_W];
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                present_next = present_c;
                full_next    = full_c;
                anysel_next  = |sel_vec;
                if (cmd_reg == oks_pkg::CMD_INSERT && !present_c && !full_c)
                    count_next = count_reg + oks_pkg::CNT_W'(1);
                else if (cmd_reg == oks_pkg::CMD_DELETE && present_c)
                    count_next = count_reg - oks_pkg::CNT_W'(1);
                state_next = S_REDUCE;
            end
            S_REDUCE:
            begin
                // hold until the result register is free
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = oks_pkg::OUT_W'({oks_pkg::OCC_W'(count_reg),
                                                    res_status, res_value});
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            m_data_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            m_data_reg  <= m_data_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        key_reg     <= key_next;
        rank_reg    <= rank_next;
        present_reg <= present_next;
        full_reg    <= full_next;
        anysel_reg  <= anysel_next;
    end

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

[rtl/oks_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module oks_checker
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [oks_pkg::OUT_W-1:0] m_tdata
);

    logic [oks_pkg::KEY_BITS-1:0] value;
    logic [oks_pkg::STAT_W-1:0]   status;
    logic [oks_pkg::OCC_W-1:0]    occ;
    logic                         req_seen;

    assign value    = m_tdata[oks_pkg::KEY_BITS-1:0];
    assign status   = m_tdata[oks_pkg::OUT_STAT_LO +: oks_pkg::STAT_W];
    assign occ      = m_tdata[oks_pkg::OUT_OCC_LO +: oks_pkg::OCC_W];
    assign req_seen = s_tvalid && s_tready;

    `AST_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready,
              m_tvalid && $stable(m_tdata))
    `AST_NOW(a_absent_minus_one, clk, rst_n,
             m_tvalid && status == oks_pkg::ST_ABSENT, value == '1)
    `AST_NOW(a_full_at_capacity, clk, rst_n,
             m_tvalid && status == oks_pkg::ST_FULL,
             occ == oks_pkg::OCC_W'(oks_pkg::CAPACITY) && value == '1)
    `AST_NOW(a_status_code, clk, rst_n, m_tvalid,
             status == oks_pkg::ST_DONE || status == oks_pkg::ST_ABSENT ||
             status == oks_pkg::ST_FULL)
    `AST_NEXT(a_no_early_result, clk, rst_n, req_seen, !s_tready)

endmodule

bind ordered_key_set_engine_unit oks_checker u_oks_checker (.*);

[dv/tb_ordered_key_set_engine_unit.sv]
`timescale 1ns / 1ps
module tb_ordered_key_set_engine_unit;
    import oks_pkg::*;

    localparam logic [CMD_W-1:0]    CMD_SPARE6  = 3'd6;
    localparam logic [CMD_W-1:0]    CMD_SPARE7  = 3'd7;
    localparam logic [KEY_BITS-1:0] NO_KEY      = '1;
    localparam logic [KEY_BITS-1:0] KEY_MOST_NEG = 32'h8000_0000;
    localparam logic [KEY_BITS-1:0] KEY_MOST_POS = 32'h7fff_ffff;
    localparam int STALL_MAX   = 13;
    localparam int HOLD_CYCLES = 300;
    localparam int STUCK_LIMIT = 2000;

    typedef struct {
        logic [KEY_BITS-1:0] value;
        status_t             status;
        logic [OCC_W-1:0]    occ;
    } set_result_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;   // cmd, key, rank, zero pad
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;   // value, status, occupancy, zero pad

    // mirror of the sorted table
    logic signed [KEY_BITS-1:0] set_keys [CAPACITY];
    int                         set_count;

    set_result_t pending_results[$];
    int          errors;
    bit          tx_idle;
    bit          rx_idle;
    int          hold_len;
    int          stuck_cycles;

    ordered_key_set_engine_unit uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    // Applies one command to the mirror table and returns what the block should answer.
    function automatic set_result_t apply_set_cmd(input logic [CMD_W-1:0] cmd,
                                                  input logic signed [KEY_BITS-1:0] key,
                                                  input logic [RANK_W-1:0] rank);
        set_result_t r;
        int          pos;
        int          i;
        bit          hit;
        r.value  = NO_KEY;
        r.status = ST_ABSENT;
        pos = 0;
        while (pos < set_count && set_keys[pos] < key)
            pos++;
        hit = (pos < set_count) && (set_keys[pos] == key);
        case (cmd)
            CMD_INSERT:
            begin
                if (hit)
                begin
                    r.value  = key;
                    r.status = ST_DONE;
                end
                else if (set_count >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    for (i = set_count; i > pos; i--)
                        set_keys[i] = set_keys[i-1];
                    set_keys[pos] = key;
                    set_count++;
                    r.value  = key;
                    r.status = ST_DONE;
                end
            end
            CMD_DELETE:
            begin
                if (hit)
                begin
                    for (i = pos; i + 1 < set_count; i++)
                        set_keys[i] = set_keys[i+1];
                    set_count--;
                    r.value  = key;
                    r.status = ST_DONE;
                end
            end
            CMD_FIND:
            begin
                if (hit)
                begin
                    r.value  = key;
                    r.status = ST_DONE;
                end
            end
            CMD_MIN:
            begin
                if (set_count > 0)
                begin
                    r.value  = set_keys[0];
                    r.status = ST_DONE;
                end
            end
            CMD_MAX:
            begin
                if (set_count > 0)
                begin
                    r.value  = set_keys[set_count-1];
                    r.status = ST_DONE;
                end
            end
            CMD_RANK:
            begin
                if (int'(rank) >= 1 && int'(rank) <= set_count)
                begin
                    r.value  = set_keys[int'(rank) - 1];
                    r.status = ST_DONE;
                end
            end
            default:
            begin
            end
        endcase
        r.occ = set_count[OCC_W-1:0];
        return r;
    endfunction

    task automatic send_request(input logic [CMD_W-1:0] cmd,
                                input logic [KEY_BITS-1:0] key,
                                input logic [RANK_W-1:0] rank);
        int gap;
        gap = tx_idle ? $urandom_range(0, STALL_MAX) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_W - IN_BITS){1'b0}}, rank, key, cmd};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.push_back(apply_set_cmd(cmd, key, rank));
    endtask

    // Keys from the current contents, small values, random words and extremes so hits, duplicates and misses all occur.
    function automatic logic [KEY_BITS-1:0] pick_key();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4 && set_count > 0)
            return set_keys[$urandom_range(0, set_count - 1)];
        else if (sel < 7)
            return $urandom_range(0, 40) - 20;
        else if (sel < 9)
            return $urandom;
        case ($urandom_range(0, 3))
            0: return KEY_MOST_NEG + $urandom_range(0, 1);
            1: return KEY_MOST_POS - $urandom_range(0, 1);
            2: return '0;
            default: return NO_KEY;
        endcase
    endfunction

    task automatic random_request(input int ins_w, input int del_w);
        int                pick;
        logic [CMD_W-1:0]  cmd;
        logic [RANK_W-1:0] rank;
        pick = $urandom_range(0, ins_w + del_w + 45);
        if (pick < ins_w)
            cmd = CMD_INSERT;
        else if (pick < ins_w + del_w)
            cmd = CMD_DELETE;
        else
        begin
            pick -= ins_w + del_w;
            if (pick < 15)
                cmd = CMD_FIND;
            else if (pick < 23)
                cmd = CMD_MIN;
            else if (pick < 31)
                cmd = CMD_MAX;
            else if (pick < 43)
                cmd = CMD_RANK;
            else
                cmd = $urandom_range(0, 1) ? CMD_SPARE6 : CMD_SPARE7;
        end
        if ($urandom_range(0, 7) == 0)
            rank = RANK_W'($urandom_range(0, 255));
        else
            rank = RANK_W'($urandom_range(0, set_count + 2));
        send_request(cmd, pick_key(), rank);
    endtask

    task automatic test_directed();
        tx_idle = 1;
        rx_idle = 1;
        send_request(CMD_MIN, '0, '0);
        send_request(CMD_MAX, '0, '0);
        send_request(CMD_RANK, '0, 8'd1);
        send_request(CMD_FIND, 32'd5, '0);
        send_request(CMD_DELETE, 32'd5, '0);
        send_request(CMD_INSERT, KEY_MOST_NEG, '0);
        send_request(CMD_INSERT, KEY_MOST_POS, '0);
        send_request(CMD_INSERT, '0, '0);
        send_request(CMD_INSERT, NO_KEY, '0);
        send_request(CMD_INSERT, '0, '0);
        send_request(CMD_FIND, NO_KEY, '0);
        send_request(CMD_FIND, 32'd1, '0);
        send_request(CMD_MIN, '0, '0);
        send_request(CMD_MAX, '0, '0);
        send_request(CMD_RANK, '0, 8'd0);
        send_request(CMD_RANK, '0, 8'd4);
        send_request(CMD_RANK, '0, 8'd5);
        send_request(CMD_RANK, '0, 8'd255);
        send_request(CMD_SPARE6, 32'haaaa_5555, 8'hff);
        send_request(CMD_SPARE7, 32'h5555_aaaa, 8'h01);
        send_request(CMD_DELETE, KEY_MOST_NEG, '0);
        send_request(CMD_DELETE, KEY_MOST_NEG, '0);
        send_request(CMD_MIN, '0, '0);
        send_request(CMD_DELETE, KEY_MOST_POS, '0);
        send_request(CMD_MAX, '0, '0);
    endtask

    // Fill to capacity, work at full, then drain to empty.
    task automatic test_full_table();
        int i;
        tx_idle = 1;
        rx_idle = 1;
        while (set_count < CAPACITY)
            send_request(CMD_INSERT, $urandom, '0);
        send_request(CMD_INSERT, $urandom, '0);
        send_request(CMD_INSERT, set_keys[$urandom_range(0, CAPACITY - 1)], '0);
        send_request(CMD_RANK, '0, 8'(CAPACITY));
        send_request(CMD_RANK, '0, 8'(CAPACITY + 1));
        send_request(CMD_MAX, '0, '0);
        for (i = 0; i < 60; i++)
            random_request(50, 12);
        while (set_count > 0)
            send_request(CMD_DELETE, set_keys[$urandom_range(0, set_count - 1)], '0);
        send_request(CMD_MIN, '0, '0);
        send_request(CMD_RANK, '0, 8'd1);
    endtask

    task automatic test_random_phases();
        int round;
        int i;
        for (round = 0; round < 3; round++)
        begin
            tx_idle = (round != 1);
            rx_idle = (round != 2);
            for (i = 0; i < 75; i++)
                random_request(60, 10);
            for (i = 0; i < 75; i++)
                random_request(30, 30);
            for (i = 0; i < 75; i++)
                random_request(10, 50);
        end
    endtask

    task automatic test_back_to_back();
        int i;
        tx_idle = 0;
        rx_idle = 0;
        for (i = 0; i < 250; i++)
            random_request(35, 25);
    endtask

    // Receiver stops for a long stretch while requests keep coming.
    task automatic test_backpressure();
        int i;
        tx_idle  = 0;
        rx_idle  = 1;
        hold_len = HOLD_CYCLES;
        for (i = 0; i < 40; i++)
            random_request(40, 20);
    endtask

    task automatic report_field(input string name, input logic [KEY_BITS-1:0] exp_val,
                                input logic [KEY_BITS-1:0] act_val);
        errors++;
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_val, act_val);
    endtask

    always @(posedge clk)
    begin : result_check
        set_result_t exp_res;
        if (m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report_field("unexpected result", '0, m_tdata[KEY_BITS-1:0]);
            else
            begin
                exp_res = pending_results.pop_front();
                if (m_tdata[KEY_BITS-1:0] !== exp_res.value)
                    report_field("value", exp_res.value, m_tdata[KEY_BITS-1:0]);
                if (m_tdata[OUT_STAT_LO +: STAT_W] !== exp_res.status)
                    report_field("status", exp_res.status, m_tdata[OUT_STAT_LO +: STAT_W]);
                if (m_tdata[OUT_OCC_LO +: OCC_W] !== exp_res.occ)
                    report_field("occupancy", exp_res.occ, m_tdata[OUT_OCC_LO +: OCC_W]);
            end
        end
    end

    initial
    begin : result_sink
        int stall;
        int n;
        wait (rst_n);
        forever
        begin
            if (hold_len > 0)
            begin
                n        = hold_len;
                hold_len = 0;
                m_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            stall = rx_idle ? $urandom_range(0, STALL_MAX) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        set_count    = 0;
        errors       = 0;
        tx_idle      = 1;
        rx_idle      = 1;
        hold_len     = 0;
        stuck_cycles = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_table();
        test_random_phases();
        test_back_to_back();
        test_backpressure();
        test_random_phases();

        s_tvalid <= 1'b0;
        while (pending_results.size() > 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/oks_pkg.sv
rtl/oks_cell.sv
rtl/oks_reduce.sv
rtl/ordered_key_set_engine_unit.sv
rtl/oks_checker.sv
dv/tb_ordered_key_set_engine_unit.sv
